FILE: hw/rtl/mksr_pkg.sv
// shared types and constants for the multi-key search and replace block
`timescale 1ns / 1ps

package mksr_pkg;

  typedef enum logic [2:0] {
    MODE_KEY_BYTE   = 3'd0,
    MODE_SUBST_BYTE = 3'd1,
    MODE_KEY_LEN    = 3'd2,
    MODE_SUBST_LEN  = 3'd3,
    MODE_TEXT       = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_EMIT,
    ST_FLUSH,
    ST_CLOSE
  } state_t;

  localparam logic [7:0] REG_KEY_COUNT = 8'd0;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic push;
    logic decide;
    logic emit;
    logic emit_last;
    logic emit_empty;
    logic drop;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic emit_done;
    logic out_busy;
  } status_t;

endpackage

FILE: hw/rtl/mksr_datapath.sv
// window, key and substitution stores, matcher and output register
`timescale 1ns / 1ps

module mksr_datapath import mksr_pkg::*; #(
  parameter int NUM_KEYS  = 4,
  parameter int KEY_LEN   = 8,
  parameter int SUBST_LEN = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output status_t    status,
  input  logic [2:0] in_mode,
  input  logic [1:0] in_slot,
  input  logic [2:0] in_pos,
  input  logic [7:0] in_data,
  input  logic [2:0] key_count,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       out_last
);

  localparam int KW = $clog2(KEY_LEN + 1);
  localparam int SW = $clog2(SUBST_LEN + 1);
  localparam int KI = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
  localparam int SI = (SUBST_LEN > 1) ? $clog2(SUBST_LEN) : 1;
  localparam int NW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CW = $clog2(NUM_KEYS + 1);

  logic [7:0]    key_store   [NUM_KEYS][KEY_LEN];
  logic [7:0]    subst_store [NUM_KEYS][SUBST_LEN];
  logic [KW-1:0] key_length  [NUM_KEYS];
  logic [SW-1:0] subst_length[NUM_KEYS];
  logic [7:0]    lookahead   [KEY_LEN];
  logic [KW-1:0] fill;

  logic [NW-1:0] win_key;
  logic [KW-1:0] drop_cnt;
  logic [SW-1:0] emit_len;
  logic [SW-1:0] emit_idx;
  logic          win_is_key;

  // word waiting in the output register until its last flag is known
  logic          held;
  logic          hold_mode;
  logic          emit_slot;
  logic          will_emit;

  logic [NUM_KEYS-1:0] hit;
  logic [CW-1:0]       keys_used;

  assign keys_used = (32'(key_count) > NUM_KEYS) ? CW'(NUM_KEYS) : CW'(key_count);

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      hit[k] = (key_length[k] != '0) && (key_length[k] <= fill) && (CW'(k) < keys_used);
      for (int i = 0; i < KEY_LEN; i++) begin
        if ((KW'(i) < key_length[k]) && (lookahead[i] != key_store[k][i])) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

  logic          any_hit;
  logic [NW-1:0] first_hit;
  always_comb begin
    any_hit   = 1'b0;
    first_hit = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        any_hit   = 1'b1;
        first_hit = NW'(k);
      end
    end
  end

  logic          slot_ok;
  logic [7:0]    load_len;
  assign slot_ok  = 32'(in_slot) < NUM_KEYS;
  assign load_len = in_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_length[k]   <= '0;
        subst_length[k] <= '0;
      end
    end else if (cmd.load && slot_ok) begin
      unique case (in_mode)
        MODE_KEY_BYTE: begin
          if (32'(in_pos) < KEY_LEN) key_store[NW'(in_slot)][KI'(in_pos)] <= in_data;
        end
        MODE_SUBST_BYTE: begin
          if (32'(in_pos) < SUBST_LEN) subst_store[NW'(in_slot)][SI'(in_pos)] <= in_data;
        end
        MODE_KEY_LEN: begin
          key_length[NW'(in_slot)] <= (32'(load_len) > KEY_LEN) ? KW'(KEY_LEN) : KW'(load_len);
        end
        MODE_SUBST_LEN: begin
          subst_length[NW'(in_slot)] <=
            (32'(load_len) > SUBST_LEN) ? SW'(SUBST_LEN) : SW'(load_len);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      for (int i = 0; i < KEY_LEN; i++) lookahead[i] <= '0;
    end else if (cmd.push) begin
      if (32'(fill) < KEY_LEN) begin
        lookahead[KI'(fill)] <= in_data;
        fill <= fill + KW'(1);
      end
    end else if (cmd.drop) begin
      if (drop_cnt >= fill) begin
        fill <= '0;
      end else begin
        for (int i = 0; i < KEY_LEN; i++) begin
          if (32'(i) + 32'(drop_cnt) < KEY_LEN) begin
            lookahead[i] <= lookahead[KI'(32'(i) + 32'(drop_cnt))];
          end
        end
        fill <= fill - drop_cnt;
      end
    end
  end

  // during a flush a word is first held, then released when the next one comes
  assign hold_mode = cmd.emit_last;
  assign emit_slot = cmd.emit && !status.out_busy && (emit_idx < emit_len);
  assign will_emit = emit_slot && !(hold_mode && held);

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      win_is_key <= any_hit;
      win_key    <= first_hit;
      drop_cnt   <= any_hit ? key_length[first_hit] : KW'(1);
      emit_len   <= any_hit ? subst_length[first_hit] : SW'(1);
      emit_idx   <= '0;
    end else if (will_emit) begin
      emit_idx <= emit_idx + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held      <= 1'b0;
    end else if (!status.out_busy) begin
      if (cmd.emit_empty) begin
        out_valid <= 1'b1;
        held      <= 1'b0;
      end else if (emit_slot && hold_mode) begin
        out_valid <= held;
        held      <= !held;
      end else begin
        out_valid <= emit_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!status.out_busy) begin
      if (cmd.emit_empty) begin
        if (!held) begin
          out_byte <= '0;
          has_byte <= 1'b0;
        end
        out_last <= 1'b1;
      end else if (will_emit) begin
        out_byte <= win_is_key ? subst_store[win_key][SI'(emit_idx)] : lookahead[0];
        has_byte <= 1'b1;
        out_last <= 1'b0;
      end
    end
  end

  assign status.out_busy  = out_valid && !out_ready;
  assign status.full      = 32'(fill) >= KEY_LEN;
  assign status.empty     = fill == '0;
  assign status.emit_done = emit_idx >= emit_len;

endmodule

FILE: hw/rtl/mksr_ctrl.sv
// sequencer for loads, decisions, substitution bursts and the closing flush
`timescale 1ns / 1ps

module mksr_ctrl import mksr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_mode,
  input  logic       in_last,
  input  status_t    status,
  output cmd_t       cmd
);

  state_t state, state_next;
  logic   flushing, flushing_next;
  logic   fire;

  assign fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      flushing <= 1'b0;
    end else begin
      state    <= state_next;
      flushing <= flushing_next;
    end
  end

  always_comb begin
    state_next    = state;
    flushing_next = flushing;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (fire) begin
          if (in_mode == MODE_TEXT) begin
            cmd.push      = 1'b1;
            flushing_next = in_last;
            state_next    = in_last ? ST_FLUSH : ST_DECIDE;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_DECIDE: begin
        if (status.full) begin
          cmd.decide = 1'b1;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!status.empty) begin
          cmd.decide = 1'b1;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_CLOSE;
        end
      end
      ST_EMIT: begin
        cmd.emit      = 1'b1;
        cmd.emit_last = flushing;
        if (status.emit_done) begin
          cmd.drop   = 1'b1;
          state_next = flushing ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_CLOSE: begin
        if (!status.out_busy) begin
          cmd.emit_empty = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/multi_key_search_replace.sv
// top level of the multi-key search and replace block
//  channel   dir   contents
//  s_axis    in    tdata = mode, slot, pos, data_byte; tuser = last
//  m_axis    out   tdata = out_byte; tuser = has_byte, out_last
//  apb       in    key_count at address 0
// loads are taken in the idle state; a text byte that leaves the window short
// passes through the decide state, one that fills it also emits its output words
// the last byte flushes the window one decision at a time, in the flush and emit
// states; each word is held in the output register until the next word or the
// closing state sets its last flag; the closing state ends the flush
// m_axis stalls hold the sequencer in its emit and closing states
// reset clears lengths, window fill and key_count; stores stay undefined
`timescale 1ns / 1ps

module multi_key_search_replace import mksr_pkg::*; #(
  parameter int NUM_KEYS  = 4,
  parameter int KEY_LEN   = 8,
  parameter int SUBST_LEN = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // mode[2:0], slot[4:3], pos[7:5], data_byte[15:8]
  input  logic        s_axis_tuser,  // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  output logic [1:0]  m_axis_tuser,  // has_byte, out_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t       cmd;
  status_t    status;
  logic [2:0] key_count;
  logic       has_byte, out_last, lastw, lastq;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_KEY_COUNT[1:0]) ? {29'd0, key_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
    end else if (psel && penable && pwrite && paddr == REG_KEY_COUNT[1:0]) begin
      key_count <= pwdata[2:0];
    end
  end

  mksr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_mode  (s_axis_tdata[2:0]),
    .in_last  (s_axis_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  mksr_datapath #(
    .NUM_KEYS  (NUM_KEYS),
    .KEY_LEN   (KEY_LEN),
    .SUBST_LEN (SUBST_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_mode   (s_axis_tdata[2:0]),
    .in_slot   (s_axis_tdata[4:3]),
    .in_pos    (s_axis_tdata[7:5]),
    .in_data   (s_axis_tdata[15:8]),
    .key_count (key_count),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_byte  (m_axis_tdata),
    .has_byte  (has_byte),
    .out_last  (lastw)
  );

  // final word of a flush is marked when nothing more follows
  assign lastq    = 1'b0;
  assign out_last = lastw | lastq;
  assign m_axis_tuser = {out_last, has_byte};

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for the multi-key search and replace block
`timescale 1ns / 1ps

module tb_top import mksr_pkg::*; ;

  typedef struct {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;
  } word_t;

  class replace_scoreboard;
    logic [7:0] key_bytes[4][8];
    logic [7:0] sub_bytes[4][8];
    int         key_len[4];
    int         sub_len[4];
    logic [7:0] window[8];
    int         fill;
    int         key_count;
    word_t      pending[$];
    int         errors;

    function void clear();
      for (int k = 0; k < 4; k++) begin
        key_len[k] = 0;
        sub_len[k] = 0;
        for (int i = 0; i < 8; i++) begin
          key_bytes[k][i] = 8'd0;
          sub_bytes[k][i] = 8'd0;
        end
      end
      for (int i = 0; i < 8; i++) window[i] = 8'd0;
      fill = 0;
      key_count = 0;
      errors = 0;
    endfunction

    function void push_word(logic [7:0] b, logic has);
      word_t w;
      w.out_byte = b;
      w.has_byte = has;
      w.out_last = 1'b0;
      pending.push_back(w);
    endfunction

    function void drop_head(int cnt);
      if (cnt >= fill) begin
        fill = 0;
      end else begin
        for (int i = 0; i < fill - cnt; i++) window[i] = window[i + cnt];
        fill -= cnt;
      end
    endfunction

    function void decide();
      int  keys;
      bit  hit;
      keys = key_count > 4 ? 4 : key_count;
      for (int k = 0; k < keys; k++) begin
        if (key_len[k] == 0 || key_len[k] > fill) continue;
        hit = 1;
        for (int i = 0; i < key_len[k]; i++)
          if (window[i] != key_bytes[k][i]) hit = 0;
        if (hit) begin
          for (int i = 0; i < sub_len[k]; i++) push_word(sub_bytes[k][i], 1'b1);
          drop_head(key_len[k]);
          return;
        end
      end
      push_word(window[0], 1'b1);
      drop_head(1);
    endfunction

    function void note_item(logic [2:0] m, logic [1:0] slot, logic [2:0] pos,
                            logic [7:0] data, logic last);
      int start;
      start = pending.size();
      case (m)
        MODE_KEY_BYTE:   key_bytes[slot][pos] = data;
        MODE_SUBST_BYTE: sub_bytes[slot][pos] = data;
        MODE_KEY_LEN:    key_len[slot] = data > 8 ? 8 : data;
        MODE_SUBST_LEN:  sub_len[slot] = data > 8 ? 8 : data;
        MODE_TEXT: begin
          if (fill < 8) begin
            window[fill] = data;
            fill++;
          end
          if (!last) begin
            if (fill >= 8) decide();
          end else begin
            while (fill > 0) decide();
            if (pending.size() == start) push_word(8'd0, 1'b0);
            pending[pending.size() - 1].out_last = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic [7:0] b, logic has, logic lst);
      word_t w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: byte %02h has %0d last %0d", b, has, lst);
        return;
      end
      w = pending.pop_front();
      if (w.out_byte !== b || w.has_byte !== has || w.out_last !== lst) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected byte %02h has %0d last %0d, got %02h has %0d last %0d",
                   w.out_byte, w.has_byte, w.out_last, b, has, lst);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // mode, slot, pos, data_byte
  logic        s_axis_tuser;   // last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // out_byte
  logic [1:0]  m_axis_tuser;   // has_byte, out_last
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  replace_scoreboard sb;
  int burst_left;
  int item_count;
  int idle_cycles;
  int rx_phase;
  bit seen_accept;

  multi_key_search_replace u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: alternating stretches of steady readiness and random backpressure
  always @(negedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_phase[6])
      m_axis_tready <= ($urandom_range(0, 9) < 6);
    else
      m_axis_tready <= 1'b1;
  end

  always @(posedge clk) begin
    seen_accept = 0;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_word(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
      seen_accept = 1;
    end
    if (!rst && ((s_axis_tvalid && s_axis_tready) || (psel && penable))) seen_accept = 1;
    if (rst || seen_accept) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 5000) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [15:0] pack_item(logic [2:0] m, logic [1:0] slot, logic [2:0] pos,
                                            logic [7:0] data);
    return {data, pos, slot, m};
  endfunction

  task automatic send_item(logic [15:0] d, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        @(negedge clk) s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(d[2:0], d[4:3], d[7:5], d[15:8], last);
    item_count++;
  endtask

  task automatic drain();
    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_key_count(logic [31:0] v);
    drain();
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_KEY_COUNT[1:0];
    pwdata  <= v;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk) sb.key_count = v[2:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_byte(logic [2:0] m, int slot, int pos, logic [7:0] data);
    send_item(pack_item(m, slot[1:0], pos[2:0], data), 1'($urandom_range(0, 1)));
  endtask

  task automatic set_pair(int slot, string k, int klen, string s, int slen);
    for (int i = 0; i < k.len(); i++) load_byte(MODE_KEY_BYTE, slot, i, k[i]);
    for (int i = 0; i < s.len(); i++) load_byte(MODE_SUBST_BYTE, slot, i, s[i]);
    load_byte(MODE_KEY_LEN, slot, 0, 8'(klen));
    load_byte(MODE_SUBST_LEN, slot, 0, 8'(slen));
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++)
      send_item(pack_item(MODE_TEXT, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), s[i]),
                i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 9) < 8) return 8'(8'h61 + $urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_len();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(9, 255);
      2: return 8;
      default: return $urandom_range(1, 3);
    endcase
  endfunction

  task automatic load_random_keys();
    int klen;
    int slen;
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 2) == 0) continue;
      klen = pick_len();
      for (int i = 0; i < 8 && i < klen; i++) load_byte(MODE_KEY_BYTE, k, i, pick_byte());
      slen = $urandom_range(0, 8);
      for (int i = 0; i < slen; i++)
        load_byte(MODE_SUBST_BYTE, k, i, 8'($urandom_range(0, 255)));
      load_byte(MODE_KEY_LEN, k, 0, 8'(klen));
      load_byte(MODE_SUBST_LEN, k, 0, 8'(pick_len()));
    end
  endtask

  task automatic send_noise();
    send_item(pack_item(3'($urandom_range(5, 7)), 2'($urandom_range(0, 3)),
                        3'($urandom_range(0, 7)), 8'($urandom_range(0, 255))),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_text(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) load_byte(MODE_KEY_BYTE, $urandom_range(0, 3),
                                                $urandom_range(0, 7), pick_byte());
      if ($urandom_range(0, 29) == 0) send_noise();
      send_item(pack_item(MODE_TEXT, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                          pick_byte()),
                i == n - 1);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 16'd0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 2'd0;
    pwdata = 32'd0;
    burst_left = 0;
    item_count = 0;
    idle_cycles = 0;
    rx_phase = 0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // fill every store entry so no unwritten byte is ever read
    for (int k = 0; k < 4; k++)
      for (int i = 0; i < 8; i++) begin
        load_byte(MODE_KEY_BYTE, k, i, 8'($urandom_range(0, 255)));
        load_byte(MODE_SUBST_BYTE, k, i, 8'($urandom_range(0, 255)));
      end

    // directed
    send_str("ab");
    write_key_count(4);
    set_pair(0, "ab", 2, "X", 1);
    set_pair(1, "abc", 3, "YY", 2);
    set_pair(2, "", 0, "", 0);
    set_pair(3, "aaaaaaaa", 200, "QRSTUVWX", 12);
    send_noise();
    send_str("abcabz");
    send_str("aaaaaaaaac");
    set_pair(0, "z", 1, "", 0);
    send_str("z");
    write_key_count(7);
    send_str("zzab");
    write_key_count(0);
    send_str("ab");
    drain();

    // random
    while (item_count < 250) begin
      if ($urandom_range(0, 3) == 0) write_key_count($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 0) load_random_keys();
      if ($urandom_range(0, 4) == 0) send_noise();
      send_text($urandom_range(0, 9) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 12));
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: multi_key_search_replace.f
hw/rtl/mksr_pkg.sv
hw/rtl/mksr_datapath.sv
hw/rtl/mksr_ctrl.sv
hw/rtl/multi_key_search_replace.sv
sim/tb_top.sv
